### rtl/bpot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpot_pkg
// Shared types and constants of the bit pattern occurrence tracker.
// ----------------------------------------------------------------------------
package bpot_pkg;

  localparam int STORE_BITS_DEF = 1024;
  localparam int LEN_W          = 11;
  localparam int POS_W          = 10;
  localparam int CMD_W          = 2;
  localparam int TOTAL_W        = 10;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 16;

  localparam logic [LEN_W-1:0]   COUNT_MAX = 11'd2047;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 10'd1023;

  localparam logic [CMD_W-1:0] CMD_WRITE        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_ANSWER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR        = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DEC,
    S_INC,
    S_DONE
  } state_t;

endpackage

### rtl/bit_pattern_occurrence_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_pattern_occurrence_tracker
// Bit store with a running count of 1100 windows inside the configured length.
// ----------------------------------------------------------------------------
// Write in range: one bit memory read per cycle over the seven neighbouring
// bits, then one shared adder step for removal and one for add-back. Only a
// write-and-answer loads a result, in S_DONE, which waits while the output stalls.
// Write out of range goes straight to S_DONE. s_tready is high only in S_IDLE.
// Clear: the whole store is swept, one entry a cycle. Reset is synchronous; after
// reset the store is swept with s_tready low. Configuration writes are taken at any time.
module bit_pattern_occurrence_tracker #(
  parameter int STORE_BITS = bpot_pkg::STORE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cmd [1:0], position [11:2], bit_value [12], zeros [15:13]
  input  logic [bpot_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // found [0], match_total [10:1], zeros [15:11]
  output logic [bpot_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpot_pkg::LEN_W-1:0]       cfg_data
);
  import bpot_pkg::*;

  localparam int AW = $clog2(STORE_BITS);
  localparam int LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam logic [LW-1:0] STORE_LEN = LW'(STORE_BITS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BITS - 1);
  localparam logic [LW-1:0] WIN_SPAN  = LW'(3);

  state_t state, state_next;

  logic [LEN_W-1:0]   string_length;
  logic [CMD_W-1:0]   cmd_q;
  logic [POS_W-1:0]   pos_q;
  logic               val_q;
  logic [2:0]         step;
  logic               rd_ok_q;
  logic [6:0]         win;
  logic [LEN_W-1:0]   count;
  logic [AW-1:0]      clr_ptr;
  logic               found;
  logic [TOTAL_W-1:0] match_total;

  logic [CMD_W-1:0] s_cmd;
  logic [POS_W-1:0] s_pos;
  logic             s_bit;
  logic             s_xfer;
  logic [LW-1:0]    len_eff;
  logic [LW-1:0]    rd_pos;
  logic             rd_ok;
  logic [6:0]       win_new;
  logic [3:0]       win_valid;
  logic             old_hit;
  logic             new_hit;
  logic [LEN_W-1:0] delta;
  logic [LEN_W-1:0] sum;
  logic             use_add;
  logic             load;
  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic             ram_wr_data;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic             ram_rd_data;

  assign s_cmd  = s_tdata[1:0];
  assign s_pos  = s_tdata[11:2];
  assign s_bit  = s_tdata[12];
  assign s_xfer = s_tvalid && s_tready;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(OUT_TDATA_W - TOTAL_W - 1){1'b0}}, match_total, found};

  assign len_eff = (LW'(string_length) > STORE_LEN) ? STORE_LEN : LW'(string_length);

  assign rd_pos = LW'(pos_q) + LW'(step);
  assign rd_ok  = (step != 3'd7) && (rd_pos >= WIN_SPAN) &&
                  ((rd_pos - WIN_SPAN) < STORE_LEN);

  always_comb begin
    win_new    = win;
    win_new[3] = val_q;
    old_hit    = 1'b0;
    new_hit    = 1'b0;
    for (int j = 0; j < 4; j++) begin
      win_valid[j] = ((LW'(pos_q) + LW'(j)) >= WIN_SPAN) &&
                     ((LW'(pos_q) + LW'(j)) < len_eff);
      old_hit = old_hit | (win_valid[j] & win[j] & win[j+1] & ~win[j+2] & ~win[j+3]);
      new_hit = new_hit |
                (win_valid[j] & win_new[j] & win_new[j+1] & ~win_new[j+2] & ~win_new[j+3]);
    end
  end

  // shared adder: minus one on removal, plus one on add-back
  assign delta   = (state == S_DEC) ? '1 : LEN_W'(1);
  assign sum     = count + delta;
  assign use_add = ((state == S_DEC) && old_hit && (count != '0)) ||
                   ((state == S_INC) && new_hit && (count != COUNT_MAX));

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_ptr == LAST_ADDR) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (s_cmd) inside
            CMD_CLEAR: state_next = S_CLEAR;
            CMD_WRITE, CMD_WRITE_ANSWER: begin
              state_next = (LW'(s_pos) < len_eff) ? S_READ : S_DONE;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        if (step == 3'd7) state_next = S_DEC;
      end
      S_DEC: state_next = S_INC;
      S_INC: state_next = S_DONE;
      S_DONE: begin
        if (cmd_q != CMD_WRITE_ANSWER || !m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = clr_ptr;
    ram_wr_data = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = AW'(rd_pos - WIN_SPAN);
    load        = 1'b0;
    unique case (state)
      S_CLEAR: ram_wr_en = 1'b1;
      S_IDLE:  s_tready = 1'b1;
      S_READ:  ram_rd_en = rd_ok;
      S_DEC:   ;
      S_INC: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = AW'(pos_q);
        ram_wr_data = val_q;
      end
      S_DONE: begin
        load = (cmd_q == CMD_WRITE_ANSWER) && (!m_tvalid || m_tready);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      string_length <= '0;
      count         <= '0;
      clr_ptr       <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        string_length <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_ptr <= clr_ptr + AW'(1);
        count   <= '0;
      end else begin
        clr_ptr <= '0;
        if (use_add) begin
          count <= sum;
        end
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_q <= rd_ok && (state == S_READ);
    if (s_xfer) begin
      cmd_q <= s_cmd;
      pos_q <= s_pos;
      val_q <= s_bit;
    end
    if (state == S_READ) begin
      step <= step + 3'd1;
      if (step != 3'd0) begin
        win <= {rd_ok_q & ram_rd_data, win[6:1]};
      end
    end else begin
      step <= 3'd0;
    end
    if (load) begin
      found       <= (count != '0);
      match_total <= (count > LEN_W'(TOTAL_MAX)) ? TOTAL_MAX : count[TOTAL_W-1:0];
    end
  end

  bpot_ram #(
    .WIDTH (1),
    .DEPTH (STORE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

### rtl/bpot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpot_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bpot_ram #(
  parameter int  WIDTH = 1,
  parameter int  DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/bpot_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpot_checker
// Port level checks of the bit pattern occurrence tracker.
// ----------------------------------------------------------------------------
module bpot_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [bpot_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [bpot_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import bpot_pkg::*;

  logic s_xfer;
  assign s_xfer = s_tvalid && s_tready;

  a_busy_after_write: assert property (@(posedge clk) disable iff (rst)
    s_xfer && (s_tdata[1:0] == CMD_WRITE || s_tdata[1:0] == CMD_WRITE_ANSWER)
    |=> !s_tready)
    else $error("input taken again straight after a write transfer");

  a_busy_during_clear: assert property (@(posedge clk) disable iff (rst)
    s_xfer && s_tdata[1:0] == CMD_CLEAR |=> ##1 !s_tready)
    else $error("input taken during clear sweep");

  a_found_matches_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[10:1] != '0)))
    else $error("found disagrees with match_total");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind bit_pattern_occurrence_tracker bpot_checker u_checker (.*);
